/* hw/rtl/idll_pkg.sv */
// shared types and constants for the indexed doubly linked list
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package idll_pkg;

   localparam int ID_W        = 10;
   localparam int ACT_W       = 2;
   localparam int TABLE_LAST  = (2 ** ID_W) - 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef logic [ACT_W-1:0] action_type;
   typedef logic [ID_W-1:0]  id_type;
   typedef logic [2:0]       kind_type;

   // request action codes
   localparam action_type ACT_INS_RIGHT = 2'd0;
   localparam action_type ACT_INS_LEFT  = 2'd1;
   localparam action_type ACT_REMOVE    = 2'd2;
   localparam action_type ACT_READ_NEXT = 2'd3;

   // classified operation kinds
   localparam kind_type KIND_NOP       = 3'd0;
   localparam kind_type KIND_INS_RIGHT = 3'd1;
   localparam kind_type KIND_INS_LEFT  = 3'd2;
   localparam kind_type KIND_REMOVE    = 3'd3;
   localparam kind_type KIND_WALK      = 3'd4;

   typedef struct packed {
      kind_type kind;
      id_type   node;
      id_type   anchor;
   } op_type;

endpackage

`default_nettype wire

/* hw/rtl/idll_front.sv */
// front end: accepts request items and classifies them into operations
// depends on idll_pkg
`timescale 1ns / 1ps
`default_nettype none

module idll_front #(
   parameter int LAST_ID = 1023
) (
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire idll_pkg::action_type    req_action,
   input  wire idll_pkg::id_type        req_node_id,
   input  wire idll_pkg::id_type        req_anchor_id,
   input  wire logic                    q_ready,
   input  wire logic                    clearing,
   output logic                         q_push,
   output idll_pkg::op_type             q_op
);
   import idll_pkg::*;

   localparam id_type LAST_ID_V = ID_W'(LAST_ID);

   logic node_ok;
   logic anchor_ok;
   logic ins_ok;

   assign node_ok   = (req_node_id != '0) && (req_node_id <= LAST_ID_V);
   assign anchor_ok = req_anchor_id <= LAST_ID_V;
   assign ins_ok    = node_ok && anchor_ok && (req_node_id != req_anchor_id);

   assign req_ready = q_ready && !clearing;
   assign q_push    = req_valid && req_ready;

   always_comb begin
      q_op.node   = req_node_id;
      q_op.anchor = req_anchor_id;
      case (req_action)
         ACT_INS_RIGHT: begin
            q_op.kind = ins_ok ? KIND_INS_RIGHT : KIND_NOP;
         end
         ACT_INS_LEFT: begin
            q_op.kind = ins_ok ? KIND_INS_LEFT : KIND_NOP;
         end
         ACT_REMOVE: begin
            q_op.kind = node_ok ? KIND_REMOVE : KIND_NOP;
         end
         ACT_READ_NEXT: begin
            q_op.kind = KIND_WALK;
         end
         default: begin
            q_op.kind = KIND_NOP;
         end
      endcase
   end

endmodule

`default_nettype wire

/* hw/rtl/idll_queue.sv */
// two-entry operation queue between front end and back end
// depends on idll_pkg
`timescale 1ns / 1ps
`default_nettype none

module idll_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire idll_pkg::op_type    push_op,
   output logic                     in_ready,
   input  wire logic                pop,
   output logic                     out_valid,
   output idll_pkg::op_type         out_op
);
   import idll_pkg::*;

   op_type             entry_ff [0:QUEUE_DEPTH-1];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign in_ready  = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_op    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/idll_back.sv */
// back end: link memories, removed marks, walk cursor and the sequencer
// that carries out one operation at a time; holds the result register
// depends on idll_pkg
`timescale 1ns / 1ps
`default_nettype none

module idll_back #(
   parameter int LAST_ID = 1023
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   input  wire idll_pkg::op_type    q_op,
   output logic                     q_pop,
   output logic                     clearing,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output idll_pkg::id_type         rsp_next_node,
   output logic                     rsp_walk_done,
   output logic                     rsp_already_removed
);
   import idll_pkg::*;

   localparam id_type LAST_ID_V = ID_W'(LAST_ID);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_LOOK  = 3'd2;
   localparam logic [2:0] ST_LINK1 = 3'd3;
   localparam logic [2:0] ST_LINK2 = 3'd4;
   localparam logic [2:0] ST_REM   = 3'd5;
   localparam logic [2:0] ST_WALK  = 3'd6;

   typedef struct packed {
      logic   we;
      id_type addr;
      id_type data;
   } link_wr_type;

   id_type right_mem [0:LAST_ID];
   id_type left_mem  [0:LAST_ID];
   logic   mark_mem  [0:LAST_ID];

   logic [2:0] state_ff, state_in;
   id_type     clr_ff, clr_in;
   id_type     cursor_ff, cursor_in;
   id_type     node_ff, node_in;
   id_type     pos_ff, pos_in;
   id_type     rlink_ff, rlink_in;

   logic       rsp_valid_ff, rsp_valid_in;
   id_type     next_ff, next_in;
   logic       done_ff, done_in;
   logic       already_ff, already_in;

   id_type      right_raddr, left_raddr, mark_raddr;
   id_type      right_q, left_q;
   logic        mark_q;
   link_wr_type right_wr, left_wr;
   logic        mark_we;
   id_type      mark_waddr;
   logic        mark_wdata;

   logic    slot_ok;
   logic    res_load;
   id_type  res_next;
   logic    res_done;
   logic    res_already;

   assign slot_ok  = !rsp_valid_ff || rsp_ready;
   assign clearing = state_ff == ST_CLEAR;

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      cursor_in   = cursor_ff;
      node_in     = node_ff;
      pos_in      = pos_ff;
      rlink_in    = rlink_ff;
      q_pop       = 1'b0;
      right_raddr = '0;
      left_raddr  = '0;
      mark_raddr  = '0;
      right_wr    = '0;
      left_wr     = '0;
      mark_we     = 1'b0;
      mark_waddr  = '0;
      mark_wdata  = 1'b0;
      res_load    = 1'b0;
      res_next    = '0;
      res_done    = 1'b0;
      res_already = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            // entry 0 gets links to node 1, every other entry zero
            right_wr.we   = 1'b1;
            right_wr.addr = clr_ff;
            right_wr.data = (clr_ff == '0) ? ID_W'(1) : '0;
            left_wr       = right_wr;
            mark_we       = 1'b1;
            mark_waddr    = clr_ff;
            clr_in        = clr_ff + 1'b1;
            if (clr_ff == LAST_ID_V) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid && slot_ok) begin
               q_pop   = 1'b1;
               node_in = q_op.node;
               case (q_op.kind)
                  KIND_INS_RIGHT: begin
                     pos_in      = q_op.anchor;
                     right_raddr = q_op.anchor;
                     state_in    = ST_LINK1;
                  end
                  KIND_INS_LEFT: begin
                     left_raddr = q_op.anchor;
                     state_in   = ST_LOOK;
                  end
                  KIND_REMOVE: begin
                     right_raddr = q_op.node;
                     left_raddr  = q_op.node;
                     mark_raddr  = q_op.node;
                     state_in    = ST_REM;
                  end
                  KIND_WALK: begin
                     right_raddr = cursor_ff;
                     state_in    = ST_WALK;
                  end
                  default: begin
                     res_load = 1'b1;
                  end
               endcase
            end
         end
         ST_LOOK: begin
            pos_in      = left_q;
            right_raddr = left_q;
            state_in    = ST_LINK1;
         end
         ST_LINK1: begin
            rlink_in      = right_q;
            right_wr.we   = 1'b1;
            right_wr.addr = node_ff;
            right_wr.data = right_q;
            left_wr.we    = 1'b1;
            left_wr.addr  = node_ff;
            left_wr.data  = pos_ff;
            mark_we       = 1'b1;
            mark_waddr    = node_ff;
            state_in      = ST_LINK2;
         end
         ST_LINK2: begin
            right_wr.we   = 1'b1;
            right_wr.addr = pos_ff;
            right_wr.data = node_ff;
            left_wr.we    = 1'b1;
            left_wr.addr  = rlink_ff;
            left_wr.data  = node_ff;
            res_load      = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_REM: begin
            res_load = 1'b1;
            if (mark_q) begin
               res_already = 1'b1;
            end else begin
               mark_we       = 1'b1;
               mark_waddr    = node_ff;
               mark_wdata    = 1'b1;
               left_wr.we    = 1'b1;
               left_wr.addr  = right_q;
               left_wr.data  = left_q;
               right_wr.we   = 1'b1;
               right_wr.addr = left_q;
               right_wr.data = right_q;
            end
            state_in = ST_IDLE;
         end
         ST_WALK: begin
            res_load  = 1'b1;
            res_next  = right_q;
            res_done  = right_q == '0;
            cursor_in = right_q;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      next_in      = next_ff;
      done_in      = done_ff;
      already_in   = already_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         next_in      = res_next;
         done_in      = res_done;
         already_in   = res_already;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff    <= node_in;
      pos_ff     <= pos_in;
      rlink_ff   <= rlink_in;
      next_ff    <= next_in;
      done_ff    <= done_in;
      already_ff <= already_in;
   end

   always_ff @(posedge clock) begin
      right_q <= right_mem[right_raddr];
      if (right_wr.we) begin
         right_mem[right_wr.addr] <= right_wr.data;
      end
   end

   always_ff @(posedge clock) begin
      left_q <= left_mem[left_raddr];
      if (left_wr.we) begin
         left_mem[left_wr.addr] <= left_wr.data;
      end
   end

   always_ff @(posedge clock) begin
      mark_q <= mark_mem[mark_raddr];
      if (mark_we) begin
         mark_mem[mark_waddr] <= mark_wdata;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_next_node       = next_ff;
   assign rsp_walk_done       = done_ff;
   assign rsp_already_removed = already_ff;

   // a finished result never lands on one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   // operations leave the queue only when the sequencer is free
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE))
      else $error("queue popped while busy");

   // an insert always finishes its second write pair
   a_link_pair: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LINK1) |=> (state_ff == ST_LINK2))
      else $error("insert sequence broken");

   // cursor rests on the sentinel through the clearing sweep
   a_cursor_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (cursor_ff == '0))
      else $error("cursor moved during clearing");

endmodule

`default_nettype wire

/* hw/rtl/indexed_doubly_linked_list.sv */
// top level of the indexed doubly linked list
// depends on idll_pkg, idll_front, idll_queue, idll_back
//
//  channel  direction  ports                                          handshake
//  req      in         req_action, req_node_id, req_anchor_id         req_valid / req_ready
//  rsp      out        rsp_next_node, rsp_walk_done, rsp_already_removed  rsp_valid / rsp_ready
//
// the back-end sequencer runs one operation at a time over single-port-write link memories:
// insert ST_LINK1 then ST_LINK2 (insert left ST_LOOK first), remove ST_REM, read next ST_WALK
// an accepted item is registered in the queue before the sequencer takes it; two items may wait in the queue
// after reset a sweep clears the min(MAX_NODES,1023)+1 table entries; req_ready stays low
// a stalled result holds the sequencer at its next item while the queue keeps filling
`timescale 1ns / 1ps
`default_nettype none

module indexed_doubly_linked_list #(
   parameter int MAX_NODES = 1023
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire idll_pkg::action_type    req_action,
   input  wire idll_pkg::id_type        req_node_id,
   input  wire idll_pkg::id_type        req_anchor_id,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output idll_pkg::id_type             rsp_next_node,
   output logic                         rsp_walk_done,
   output logic                         rsp_already_removed
);
   import idll_pkg::*;

   localparam int LAST_ID = (MAX_NODES > TABLE_LAST) ? TABLE_LAST : MAX_NODES;

   logic   q_ready;
   logic   clearing;
   logic   q_push;
   op_type push_op;
   logic   q_pop;
   logic   q_valid;
   op_type head_op;

   idll_front #(
      .LAST_ID (LAST_ID)
   ) u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_node_id   (req_node_id),
      .req_anchor_id (req_anchor_id),
      .q_ready       (q_ready),
      .clearing      (clearing),
      .q_push        (q_push),
      .q_op          (push_op)
   );

   idll_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_op   (push_op),
      .in_ready  (q_ready),
      .pop       (q_pop),
      .out_valid (q_valid),
      .out_op    (head_op)
   );

   idll_back #(
      .LAST_ID (LAST_ID)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (q_valid),
      .q_op                (head_op),
      .q_pop               (q_pop),
      .clearing            (clearing),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_next_node       (rsp_next_node),
      .rsp_walk_done       (rsp_walk_done),
      .rsp_already_removed (rsp_already_removed)
   );

endmodule

`default_nettype wire
